### src/sle_pkg.sv
// ----------------------------------------------------------------------------
// sle_pkg
// shared types, character codes and helpers for the string literal unescape
// ----------------------------------------------------------------------------
package sle_pkg;

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_ESC    = 3'd1,
        MODE_ESC_CR = 3'd2,
        MODE_OCT1   = 3'd3,
        MODE_OCT2   = 3'd4,
        MODE_HEX0   = 3'd5,
        MODE_HEX1   = 3'd6
    } mode_t;

    typedef enum logic [2:0] {
        NOTE_NONE    = 3'd0,
        NOTE_OCT_BIG = 3'd1,
        NOTE_BAD_HEX = 3'd2,
        NOTE_UNKNOWN = 3'd3,
        NOTE_PERCENT = 3'd4,
        NOTE_NULL    = 3'd5,
        NOTE_UNTERM  = 3'd6
    } note_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       valid;
        note_t      note;
        logic       done;
        logic       cons;
        logic       last;
    } res_t;

    localparam int unsigned ACC_W      = 9;
    localparam int unsigned OCT_MAX    = 255;
    localparam int unsigned OUTQ_AW    = 2;
    localparam int unsigned OUTQ_DEPTH = 1 << OUTQ_AW;

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_0       = 8'h30;
    localparam logic [7:0] CH_7       = 8'h37;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_A       = 8'h61;
    localparam logic [7:0] CH_F       = 8'h66;
    localparam logic [7:0] CH_N       = 8'h6E;
    localparam logic [7:0] CH_T       = 8'h74;
    localparam logic [7:0] CH_V       = 8'h76;
    localparam logic [7:0] CH_X       = 8'h78;

    localparam logic [7:0] CODE_BEL = 8'd7;
    localparam logic [7:0] CODE_TAB = 8'd9;
    localparam logic [7:0] CODE_LF  = 8'd10;
    localparam logic [7:0] CODE_VT  = 8'd11;
    localparam logic [7:0] CODE_FF  = 8'd12;

    function automatic res_t make_res(input logic [7:0] ch, input logic valid,
                                      input note_t note, input logic done,
                                      input logic cons);
        res_t r;
        r.ch    = valid ? ch : 8'h00;
        r.valid = valid;
        r.note  = note;
        r.done  = done;
        r.cons  = cons;
        r.last  = 1'b0;
        return r;
    endfunction

    // {ok, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, 4'(b - 8'h30)};
        end else if (b >= 8'h61 && b <= 8'h66) begin
            r = {1'b1, 4'(b - 8'h57)};
        end else if (b >= 8'h41 && b <= 8'h46) begin
            r = {1'b1, 4'(b - 8'h37)};
        end
        return r;
    endfunction

endpackage

### src/sle_decode.sv
// ----------------------------------------------------------------------------
// sle_decode
// escape state update and result generation for one registered source byte
// ----------------------------------------------------------------------------
module sle_decode (
    input  sle_pkg::mode_t              mode_i,
    input  logic [sle_pkg::ACC_W-1:0]   acc_i,
    input  logic [7:0]                  byte_i,
    input  logic                        end_i,
    output sle_pkg::mode_t              mode_o,
    output logic [sle_pkg::ACC_W-1:0]   acc_o,
    output logic [1:0]                  cnt_o,
    output sle_pkg::res_t               res0_o,
    output sle_pkg::res_t               res1_o
);

    logic                      is_end;
    logic                      is_oct;
    logic [4:0]                hex;
    logic [sle_pkg::ACC_W-1:0] oct_val;
    sle_pkg::mode_t            norm_mode;
    logic                      norm_emit;
    sle_pkg::res_t             norm_res;
    sle_pkg::res_t             flush_res;
    sle_pkg::res_t             r0;
    sle_pkg::res_t             r1;
    logic [1:0]                cnt;

    assign is_end  = end_i && (byte_i == sle_pkg::CH_NUL);
    assign is_oct  = (byte_i >= sle_pkg::CH_0) && (byte_i <= sle_pkg::CH_7);
    assign hex     = sle_pkg::hex_digit(byte_i);
    assign oct_val = {acc_i[sle_pkg::ACC_W-4:0], byte_i[2:0]};

    assign flush_res = sle_pkg::make_res(acc_i[7:0], 1'b1, sle_pkg::NOTE_NONE, 1'b0, 1'b0);

    // plain text byte
    always_comb begin
        norm_mode = sle_pkg::MODE_NORMAL;
        norm_emit = 1'b1;
        norm_res  = sle_pkg::make_res(byte_i, 1'b1, sle_pkg::NOTE_NONE, 1'b0, 1'b0);
        if (byte_i == sle_pkg::CH_BSLASH) begin
            norm_mode = sle_pkg::MODE_ESC;
            norm_emit = 1'b0;
        end else if (byte_i == sle_pkg::CH_QUOTE) begin
            norm_res = sle_pkg::make_res(8'h00, 1'b0, sle_pkg::NOTE_NONE, 1'b1, 1'b1);
        end else if (byte_i == sle_pkg::CH_LF || byte_i == sle_pkg::CH_CR) begin
            norm_res = sle_pkg::make_res(8'h00, 1'b0, sle_pkg::NOTE_UNTERM, 1'b1, 1'b0);
        end else if (byte_i == sle_pkg::CH_NUL) begin
            if (is_end) begin
                norm_res = sle_pkg::make_res(8'h00, 1'b0, sle_pkg::NOTE_UNTERM, 1'b1, 1'b0);
            end else begin
                norm_res = sle_pkg::make_res(8'h00, 1'b0, sle_pkg::NOTE_NULL, 1'b0, 1'b0);
            end
        end
    end

    always_comb begin
        mode_o = sle_pkg::MODE_NORMAL;
        acc_o  = '0;
        cnt    = 2'd0;
        r0     = norm_res;
        r1     = norm_res;
        unique case (mode_i)
            sle_pkg::MODE_ESC: begin
                cnt = 2'd1;
                if (is_end) begin
                    r0 = sle_pkg::make_res(8'h00, 1'b0, sle_pkg::NOTE_UNTERM, 1'b1, 1'b0);
                end else begin
                    unique case (byte_i) inside
                        sle_pkg::CH_N: r0 = sle_pkg::make_res(sle_pkg::CODE_LF, 1'b1,
                                                              sle_pkg::NOTE_NONE, 1'b0, 1'b0);
                        sle_pkg::CH_T: r0 = sle_pkg::make_res(sle_pkg::CODE_TAB, 1'b1,
                                                              sle_pkg::NOTE_NONE, 1'b0, 1'b0);
                        sle_pkg::CH_V: r0 = sle_pkg::make_res(sle_pkg::CODE_VT, 1'b1,
                                                              sle_pkg::NOTE_NONE, 1'b0, 1'b0);
                        sle_pkg::CH_F: r0 = sle_pkg::make_res(sle_pkg::CODE_FF, 1'b1,
                                                              sle_pkg::NOTE_NONE, 1'b0, 1'b0);
                        sle_pkg::CH_A: r0 = sle_pkg::make_res(sle_pkg::CODE_BEL, 1'b1,
                                                              sle_pkg::NOTE_NONE, 1'b0, 1'b0);
                        sle_pkg::CH_BSLASH, sle_pkg::CH_QUOTE: begin
                            r0 = sle_pkg::make_res(byte_i, 1'b1, sle_pkg::NOTE_NONE,
                                                   1'b0, 1'b0);
                        end
                        sle_pkg::CH_PERCENT: begin
                            r0 = sle_pkg::make_res(byte_i, 1'b1, sle_pkg::NOTE_PERCENT,
                                                   1'b0, 1'b0);
                        end
                        sle_pkg::CH_LF: cnt = 2'd0;
                        sle_pkg::CH_CR: begin
                            cnt    = 2'd0;
                            mode_o = sle_pkg::MODE_ESC_CR;
                        end
                        sle_pkg::CH_X: begin
                            cnt    = 2'd0;
                            mode_o = sle_pkg::MODE_HEX0;
                        end
                        [sle_pkg::CH_0:sle_pkg::CH_7]: begin
                            cnt    = 2'd0;
                            mode_o = sle_pkg::MODE_OCT1;
                            acc_o  = sle_pkg::ACC_W'(byte_i[2:0]);
                        end
                        default: begin
                            r0 = sle_pkg::make_res(byte_i, 1'b1, sle_pkg::NOTE_UNKNOWN,
                                                   1'b0, 1'b0);
                        end
                    endcase
                end
            end
            sle_pkg::MODE_ESC_CR: begin
                if (byte_i != sle_pkg::CH_LF) begin
                    mode_o = norm_mode;
                    cnt    = {1'b0, norm_emit};
                end
            end
            sle_pkg::MODE_OCT1: begin
                if (is_oct) begin
                    mode_o = sle_pkg::MODE_OCT2;
                    acc_o  = oct_val;
                end else begin
                    mode_o = norm_mode;
                    cnt    = 2'd1 + {1'b0, norm_emit};
                    r0     = flush_res;
                end
            end
            sle_pkg::MODE_OCT2: begin
                if (is_oct) begin
                    cnt = 2'd1;
                    if (oct_val > sle_pkg::ACC_W'(sle_pkg::OCT_MAX)) begin
                        r0 = sle_pkg::make_res(8'h00, 1'b0, sle_pkg::NOTE_OCT_BIG,
                                               1'b0, 1'b0);
                    end else begin
                        r0 = sle_pkg::make_res(oct_val[7:0], 1'b1, sle_pkg::NOTE_NONE,
                                               1'b0, 1'b0);
                    end
                end else begin
                    mode_o = norm_mode;
                    cnt    = 2'd1 + {1'b0, norm_emit};
                    r0     = flush_res;
                end
            end
            sle_pkg::MODE_HEX0: begin
                if (is_end) begin
                    cnt = 2'd1;
                    r0  = sle_pkg::make_res(8'h00, 1'b0, sle_pkg::NOTE_UNTERM, 1'b1, 1'b0);
                end else if (!hex[4]) begin
                    cnt = 2'd1;
                    r0  = sle_pkg::make_res(byte_i, 1'b1, sle_pkg::NOTE_BAD_HEX, 1'b0, 1'b0);
                end else begin
                    mode_o = sle_pkg::MODE_HEX1;
                    acc_o  = sle_pkg::ACC_W'(hex[3:0]);
                end
            end
            sle_pkg::MODE_HEX1: begin
                if (hex[4]) begin
                    cnt = 2'd1;
                    r0  = sle_pkg::make_res({acc_i[3:0], hex[3:0]}, 1'b1,
                                            sle_pkg::NOTE_NONE, 1'b0, 1'b0);
                end else begin
                    mode_o = norm_mode;
                    cnt    = 2'd1 + {1'b0, norm_emit};
                    r0     = flush_res;
                end
            end
            default: begin
                mode_o = norm_mode;
                cnt    = {1'b0, norm_emit};
            end
        endcase
        if (cnt == 2'd1) begin
            r0.last = 1'b1;
        end
        if (cnt == 2'd2) begin
            r1.last = 1'b1;
        end
    end

    assign cnt_o  = cnt;
    assign res0_o = r0;
    assign res1_o = r1;

endmodule

### src/sle_outq.sv
// ----------------------------------------------------------------------------
// sle_outq
// small result queue, takes up to two results a cycle and gives one
// ----------------------------------------------------------------------------
module sle_outq (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic [1:0]    push_cnt,
    input  sle_pkg::res_t push0,
    input  sle_pkg::res_t push1,
    output logic          room,
    output logic          head_valid,
    output sle_pkg::res_t head,
    input  logic          head_ready
);

    sle_pkg::res_t                 entry_reg [sle_pkg::OUTQ_DEPTH];
    logic [sle_pkg::OUTQ_AW-1:0]   wr_ptr_reg;
    logic [sle_pkg::OUTQ_AW-1:0]   wr_ptr_next;
    logic [sle_pkg::OUTQ_AW-1:0]   rd_ptr_reg;
    logic [sle_pkg::OUTQ_AW-1:0]   rd_ptr_next;
    logic [sle_pkg::OUTQ_AW:0]     count_reg;
    logic [sle_pkg::OUTQ_AW:0]     count_next;
    logic [sle_pkg::OUTQ_AW-1:0]   wr_ptr_plus1;
    logic                          pop;

    assign head_valid   = (count_reg != '0);
    assign head         = entry_reg[rd_ptr_reg];
    assign pop          = head_valid && head_ready;
    assign room         = (count_reg <= (sle_pkg::OUTQ_AW + 1)'(sle_pkg::OUTQ_DEPTH - 2));
    assign wr_ptr_plus1 = wr_ptr_reg + 1'b1;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + sle_pkg::OUTQ_AW'(push_cnt);
        rd_ptr_next = rd_ptr_reg + sle_pkg::OUTQ_AW'(pop);
        count_next  = count_reg + (sle_pkg::OUTQ_AW + 1)'(push_cnt)
                      - (sle_pkg::OUTQ_AW + 1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            entry_reg[wr_ptr_reg] <= push0;
        end
        if (push_cnt == 2'd2) begin
            entry_reg[wr_ptr_plus1] <= push1;
        end
    end

endmodule

### src/string_literal_unescape.sv
// ----------------------------------------------------------------------------
// string_literal_unescape
// decodes the bytes of a c style string literal into characters and notes
// ----------------------------------------------------------------------------
//  channel  direction  tdata                         tuser                   tlast
//  s_       in         [7:0] in_byte                 -                       at_buffer_end
//  m_       out        [7:0] out_char, [8] done,     [0] char_valid,         last_of_item
//                      [9] end_consumed              [3:1] note
//
//  one source byte per cycle while the queue has room: the byte is held in an input
//  register, decoded against the escape state and written to a four entry queue
//  a byte gives zero, one or two results; the second result leaves after the first
//  through the single output port of the queue
//  reset returns the escape state to plain text and empties the queue
//  input stalls only while the queue has fewer than two free entries
// ----------------------------------------------------------------------------
module string_literal_unescape (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] out_char, [8] literal_done, [9] end_consumed
    output logic [3:0]  m_tuser,   // [0] char_valid, [3:1] note
    output logic        m_tlast
);

    logic                          in_valid_reg;
    logic [7:0]                    in_byte_reg;
    logic                          in_end_reg;
    sle_pkg::mode_t                mode_reg;
    sle_pkg::mode_t                mode_next;
    logic [sle_pkg::ACC_W-1:0]     acc_reg;
    logic [sle_pkg::ACC_W-1:0]     acc_next;
    logic [1:0]                    dec_cnt;
    sle_pkg::res_t                 dec_res0;
    sle_pkg::res_t                 dec_res1;
    logic [1:0]                    push_cnt;
    logic                          room;
    logic                          advance;
    logic                          head_valid;
    sle_pkg::res_t                 head;

    assign advance  = in_valid_reg && room;
    assign s_tready = !in_valid_reg || advance;
    assign push_cnt = advance ? dec_cnt : 2'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            mode_reg     <= sle_pkg::MODE_NORMAL;
            acc_reg      <= '0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                mode_reg <= mode_next;
                acc_reg  <= acc_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_end_reg  <= s_tlast;
        end
    end

    sle_decode u_decode (
        .mode_i (mode_reg),
        .acc_i  (acc_reg),
        .byte_i (in_byte_reg),
        .end_i  (in_end_reg),
        .mode_o (mode_next),
        .acc_o  (acc_next),
        .cnt_o  (dec_cnt),
        .res0_o (dec_res0),
        .res1_o (dec_res1)
    );

    sle_outq u_outq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_cnt   (push_cnt),
        .push0      (dec_res0),
        .push1      (dec_res1),
        .room       (room),
        .head_valid (head_valid),
        .head       (head),
        .head_ready (m_tready)
    );

    assign m_tvalid = head_valid;
    assign m_tdata  = {6'd0, head.cons, head.done, head.ch};
    assign m_tuser  = {head.note, head.valid};
    assign m_tlast  = head.last;

`ifndef NO_ASSERTIONS
    // a flushed digit code always leads a two result transaction
    assert property (@(posedge aclk) disable iff (!aresetn)
        (push_cnt == 2'd2) |-> (dec_res0.valid && !dec_res0.done && !dec_res0.last
                                && dec_res1.last))
        else $error("two result push without leading flushed character");

    // a finished literal leaves the decoder in plain text mode
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && dec_cnt != 2'd0 && (dec_res0.done || (dec_cnt == 2'd2 && dec_res1.done)))
        |=> (mode_reg == sle_pkg::MODE_NORMAL && acc_reg == '0))
        else $error("escape state kept after end of literal");

    // a held byte with no queue room keeps its state
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !room) |=> ($stable(mode_reg) && $stable(acc_reg) && in_valid_reg))
        else $error("escape state moved while stalled");

    // a single result is always the last of its byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        (push_cnt == 2'd1) |-> dec_res0.last)
        else $error("single result not marked last");
`endif

endmodule
